/* sv/ramp_to_target_stepper_core_defines.svh */
// Assertion macros shared by the ramp stepper modules.
`ifndef RAMP_TO_TARGET_STEPPER_CORE_DEFINES_SVH
`define RAMP_TO_TARGET_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rts assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rts assertion failed");

`endif

/* sv/rts_pkg.sv */
// Shared types and constants for the ramp stepper.
package rts_pkg;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_ACC  = 2'd2;

  // One remainder bit per cycle over the 16-bit phase magnitude.
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef struct packed {
    logic start;     // capture the input item
    logic exec;      // apply load/overwrite, or set up the tick
    logic div_step;  // one remainder iteration
    logic move;      // form increment and candidate position
    logic check;     // compare against target and commit
    logic finish;    // load the result registers
  } rts_cmd_t;

  typedef struct packed {
    logic tick;      // captured item is a tick
    logic neg;       // step code is negative
  } rts_sts_t;

endpackage

/* sv/rts_ctrl.sv */
// Sequencer for the ramp stepper: item handshake and step ordering.
`include "ramp_to_target_stepper_core_defines.svh"

module rts_ctrl
  import rts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rts_sts_t sts,
  output rts_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = '0;
        if (!sts.tick)    state_nxt = S_DONE;
        else if (sts.neg) state_nxt = S_DIV;
        else              state_nxt = S_MOVE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RTS_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_r == S_DIV) && (cnt_r == CNT_LAST), state_r == S_MOVE)
  `RTS_ASSERT_NEXT(a_accept_execs, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `RTS_ASSERT_NOW(a_finish_slot, clk, rst_n, cmd.finish, slot_free && (state_r == S_DONE))

endmodule

/* sv/rts_datapath.sv */
// Ramp stepper datapath: ramp state, serial phase remainder, move and snap.
`include "ramp_to_target_stepper_core_defines.svh"

module rts_datapath
  import rts_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rts_cmd_t            cmd,
  output rts_sts_t            sts,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_start_value,
  input  logic signed [31:0]  in_target_value,
  input  logic signed [15:0]  in_step_code,
  input  logic signed [15:0]  in_phase_start,
  input  logic signed [15:0]  in_acc_value,
  output logic                out_moving,
  output logic signed [31:0]  out_position,
  output logic signed [15:0]  out_acc_out,
  output logic [14:0]         out_applied_step
);

  localparam int PW = POSITION_WIDTH;

  // captured item
  logic [1:0]  func_r;
  logic [31:0] start_r, target_in_r;
  logic [15:0] step_in_r, phase_in_r, acc_in_r;

  // ramp state
  logic [PW-1:0] position_r, target_r, tmp_r;
  logic [15:0]   step_r, phase_r, acc_r;
  logic          lt_r, gt_r, moving_r;
  logic [14:0]   applied_r;

  // remainder unit
  logic [15:0] mag_r, dvd_r, rem_r;
  logic [16:0] rem_sh, rem_diff;

  // result registers
  logic          res_moving_r;
  logic [31:0]   res_position_r;
  logic [15:0]   res_acc_r;
  logic [14:0]   res_applied_r;

  logic [15:0]   inc;
  logic [PW-1:0] inc_w;
  logic [15:0]   phase_abs;

  assign sts.tick = (func_r == FUNC_TICK);
  assign sts.neg  = step_r[15];

  assign phase_abs = phase_r[15] ? (16'd0 - phase_r) : phase_r;
  assign rem_sh    = {rem_r, dvd_r[15]};
  assign rem_diff  = rem_sh - {1'b0, mag_r};

  assign inc   = step_r[15] ? {15'd0, (rem_r == 16'd0)} : step_r;
  assign inc_w = PW'(inc);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r      <= in_func;
      start_r     <= in_start_value;
      target_in_r <= in_target_value;
      step_in_r   <= in_step_code;
      phase_in_r  <= in_phase_start;
      acc_in_r    <= in_acc_value;
    end
    if (cmd.exec) begin
      mag_r <= 16'd0 - step_r;
      dvd_r <= phase_abs;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[14:0], 1'b0};
    end
    if (cmd.move) begin
      lt_r  <= $signed(position_r) < $signed(target_r);
      gt_r  <= $signed(target_r) < $signed(position_r);
      tmp_r <= ($signed(position_r) < $signed(target_r)) ? (position_r + inc_w)
                                                          : (position_r - inc_w);
    end
    if (cmd.finish) begin
      res_moving_r   <= moving_r;
      res_position_r <= 32'(position_r);
      res_acc_r      <= acc_r;
      res_applied_r  <= applied_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      target_r   <= '0;
      step_r     <= '0;
      phase_r    <= '0;
      acc_r      <= '0;
      rem_r      <= '0;
      moving_r   <= 1'b0;
      applied_r  <= '0;
    end else begin
      if (cmd.start) begin
        moving_r  <= 1'b0;
        applied_r <= '0;
      end
      if (cmd.exec) begin
        rem_r <= '0;
        case (func_r)
          FUNC_TICK: begin
            if (step_r[15]) phase_r <= phase_r + 16'd1;
          end
          FUNC_LOAD: begin
            position_r <= PW'($signed(start_r));
            target_r   <= PW'($signed(target_in_r));
            step_r     <= step_in_r;
            phase_r    <= phase_in_r;
            acc_r      <= '0;
          end
          FUNC_ACC: acc_r <= acc_in_r;
          default: ;
        endcase
      end
      if (cmd.div_step) begin
        // keep the shifted remainder when the divisor does not fit
        rem_r <= rem_diff[16] ? rem_sh[15:0] : rem_diff[15:0];
      end
      if (cmd.move) begin
        acc_r     <= acc_r + inc;
        applied_r <= inc[14:0];
      end
      if (cmd.check) begin
        if (lt_r) begin
          if (!($signed(tmp_r) < $signed(target_r))) begin
            step_r     <= '0;
            position_r <= target_r;
          end else begin
            position_r <= tmp_r;
            moving_r   <= 1'b1;
          end
        end else if (gt_r) begin
          if (!($signed(target_r) < $signed(tmp_r))) begin
            step_r     <= '0;
            position_r <= target_r;
          end else begin
            position_r <= tmp_r;
            moving_r   <= 1'b1;
          end
        end
      end
    end
  end

  assign out_moving       = res_moving_r;
  assign out_position     = res_position_r;
  assign out_acc_out      = res_acc_r;
  assign out_applied_step = res_applied_r;

  `RTS_ASSERT_NOW(a_moving_off_target, clk, rst_n, moving_r, position_r != target_r)
  `RTS_ASSERT_NOW(a_rem_below_mag, clk, rst_n, cmd.div_step, rem_r < mag_r)
  `RTS_ASSERT_NOW(a_applied_tick_only, clk, rst_n, applied_r != 15'd0, func_r == FUNC_TICK)

endmodule

/* sv/ramp_to_target_stepper_core.sv */
// Ramp stepper top level: sequencer plus datapath.
//
// Moves a position toward a target one tick at a time. func 1 loads position,
// target, step code and phase and clears the accumulator; func 2 overwrites
// the accumulator; func 0 ticks. One result per item. An item is accepted
// only while the sequencer is idle. After the accepting edge, a load,
// overwrite or unused code 3 runs the exec step and then the done step; a
// tick with a nonnegative step code runs exec, move, check and done; a tick
// with a negative step code runs exec, then the one-bit-per-cycle remainder
// of the phase magnitude by the step magnitude, then move, check and done.
// The next item may be accepted in the cycle after the result enters the
// output register, even if that result has not been taken yet; a result that
// cannot enter a still-occupied output register holds the sequencer. Position
// width is POSITION_WIDTH (16 to 64); the position port shows its low 32
// bits, zero-extended below 32.
module ramp_to_target_stepper_core
  import rts_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_start_value,
  input  logic signed [31:0] in_target_value,
  input  logic signed [15:0] in_step_code,
  input  logic signed [15:0] in_phase_start,
  input  logic signed [15:0] in_acc_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_moving,
  output logic signed [31:0] out_position,
  output logic signed [15:0] out_acc_out,
  output logic [14:0]        out_applied_step
);

  rts_cmd_t cmd;
  rts_sts_t sts;

  rts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rts_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_start_value   (in_start_value),
    .in_target_value  (in_target_value),
    .in_step_code     (in_step_code),
    .in_phase_start   (in_phase_start),
    .in_acc_value     (in_acc_value),
    .out_moving       (out_moving),
    .out_position     (out_position),
    .out_acc_out      (out_acc_out),
    .out_applied_step (out_applied_step)
  );

endmodule

/* sim/ramp_to_target_stepper_core_test.sv */
// Self-checking testbench for the ramp-to-target stepper core.
`timescale 1ns / 1ps

module ramp_to_target_stepper_core_test;
  import rts_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_value;
    logic [31:0] target_value;
    logic [15:0] step_code;
    logic [15:0] phase_start;
    logic [15:0] acc_value;
  } ramp_cmd_t;

  typedef struct packed {
    logic        moving;
    logic [31:0] position;
    logic [15:0] acc_out;
    logic [14:0] applied_step;
  } ramp_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_start_value = '0;
  logic signed [31:0] in_target_value = '0;
  logic signed [15:0] in_step_code = '0;
  logic signed [15:0] in_phase_start = '0;
  logic signed [15:0] in_acc_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_moving;
  logic signed [31:0] out_position;
  logic signed [15:0] out_acc_out;
  logic [14:0] out_applied_step;

  ramp_to_target_stepper_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_start_value   (in_start_value),
    .in_target_value  (in_target_value),
    .in_step_code     (in_step_code),
    .in_phase_start   (in_phase_start),
    .in_acc_value     (in_acc_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_moving       (out_moving),
    .out_position     (out_position),
    .out_acc_out      (out_acc_out),
    .out_applied_step (out_applied_step)
  );

  ramp_cmd_t    pending_cmds[$];
  ramp_report_t expected_reports[$];
  int mismatches = 0;

  // Predicted ramp state
  logic signed [31:0] ramp_pos = '0;
  logic signed [31:0] ramp_target = '0;
  logic [15:0] ramp_step = '0;
  logic [15:0] ramp_phase = '0;
  logic [15:0] ramp_acc = '0;

  // Handshake bookkeeping for the falling-edge drivers
  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  function automatic ramp_report_t advance_ramp(ramp_cmd_t c);
    ramp_report_t r;
    logic [15:0] inc;
    logic [16:0] mag;
    logic [16:0] ph_mag;
    r = '0;
    case (c.func)
      FUNC_TICK: begin
        if (ramp_step[15]) begin
          // fractional step: one unit when |phase| is a multiple of |code|
          mag = 17'h10000 - {1'b0, ramp_step};
          ph_mag = ramp_phase[15] ? 17'h10000 - {1'b0, ramp_phase} : {1'b0, ramp_phase};
          inc = (ph_mag % mag == 17'd0) ? 16'd1 : 16'd0;
          ramp_phase = ramp_phase + 16'd1;
        end else begin
          inc = ramp_step;
        end
        ramp_acc = ramp_acc + inc;
        r.applied_step = inc[14:0];
        if (ramp_pos < ramp_target) begin
          ramp_pos = ramp_pos + {16'd0, inc};
          if (!(ramp_pos < ramp_target)) begin
            ramp_step = '0;
            ramp_pos = ramp_target;
          end else begin
            r.moving = 1'b1;
          end
        end
        if (ramp_target < ramp_pos) begin
          ramp_pos = ramp_pos - {16'd0, inc};
          if (!(ramp_target < ramp_pos)) begin
            ramp_step = '0;
            ramp_pos = ramp_target;
          end else begin
            r.moving = 1'b1;
          end
        end
      end
      FUNC_LOAD: begin
        ramp_pos = c.start_value;
        ramp_target = c.target_value;
        ramp_step = c.step_code;
        ramp_phase = c.phase_start;
        ramp_acc = '0;
      end
      FUNC_ACC: ramp_acc = c.acc_value;
      default: ;
    endcase
    r.position = ramp_pos;
    r.acc_out = ramp_acc;
    return r;
  endfunction

  // Unused fields carry random junk so every input bit toggles
  function automatic ramp_cmd_t junk_cmd(logic [1:0] func);
    ramp_cmd_t c;
    c.func = func;
    c.start_value = $urandom;
    c.target_value = $urandom;
    c.step_code = $urandom;
    c.phase_start = $urandom;
    c.acc_value = $urandom;
    return c;
  endfunction

  task automatic push_load(logic [31:0] start_v, logic [31:0] target_v,
                           logic [15:0] step_v, logic [15:0] phase_v);
    ramp_cmd_t c;
    c = junk_cmd(FUNC_LOAD);
    c.start_value = start_v;
    c.target_value = target_v;
    c.step_code = step_v;
    c.phase_start = phase_v;
    pending_cmds.push_back(c);
  endtask

  task automatic push_acc(logic [15:0] acc_v);
    ramp_cmd_t c;
    c = junk_cmd(FUNC_ACC);
    c.acc_value = acc_v;
    pending_cmds.push_back(c);
  endtask

  task automatic push_ticks(int n);
    repeat (n) pending_cmds.push_back(junk_cmd(FUNC_TICK));
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Input driver: hold until transfer, then idle for a randomly drawn gap before the next item
  always @(negedge clk) begin
    ramp_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (in_valid) begin
        if ($urandom_range(0, 63) == 0) in_idle_on = !in_idle_on;
        in_gap = in_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (in_gap != 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end else begin
        c = pending_cmds.pop_front();
        in_func <= c.func;
        in_start_value <= c.start_value;
        in_target_value <= c.target_value;
        in_step_code <= c.step_code;
        in_phase_start <= c.phase_start;
        in_acc_value <= c.acc_value;
        in_valid <= 1'b1;
      end
    end
  end

  // Result side: stall a presented result for a randomly drawn spell before taking it
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_xfer) begin
        if ($urandom_range(0, 63) == 0) out_idle_on = !out_idle_on;
        out_stall = out_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        if (out_valid) out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    ramp_report_t want;
    ramp_cmd_t c;
    if (!rst_n) begin
      in_xfer <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      out_xfer <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result: moving %0d position %0d acc %0d step %0d",
                   $time, out_moving, out_position, out_acc_out, out_applied_step);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_moving !== want.moving) begin
            $display("%0t: moving expected %0d actual %0d", $time, want.moving, out_moving);
            mismatches++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, $signed(want.position), out_position);
            mismatches++;
          end
          if (out_acc_out !== want.acc_out) begin
            $display("%0t: acc_out expected %0d actual %0d",
                     $time, $signed(want.acc_out), out_acc_out);
            mismatches++;
          end
          if (out_applied_step !== want.applied_step) begin
            $display("%0t: applied_step expected %0d actual %0d",
                     $time, want.applied_step, out_applied_step);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        c = {in_func, in_start_value, in_target_value, in_step_code, in_phase_start,
             in_acc_value};
        expected_reports.push_back(advance_ramp(c));
      end
    end
  end

  initial begin
    int n_random;
    int n_ticks;
    logic [31:0] start_v;
    logic [31:0] target_v;
    logic [15:0] step_v;
    logic [15:0] phase_v;

    // Directed: tick at target after reset, unused code, extremes, wrap, fractional codes
    push_ticks(1);
    pending_cmds.push_back(junk_cmd(FUNC_UNUSED));
    push_load(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h0000);
    push_ticks(1);
    push_load(32'd0, 32'd10, 16'd0, 16'h0000);
    push_ticks(1);
    push_load(32'h7FFF_FFFA, 32'h7FFF_FFFF, 16'h7FFF, 16'h0000);
    push_ticks(2);
    push_load(32'h8000_0003, 32'h8000_0000, 16'd100, 16'hFFFF);
    push_ticks(1);
    push_load(32'd0, 32'd5, 16'h8000, 16'h8000);
    push_ticks(2);
    push_load(32'd0, 32'd3, 16'hFFFF, 16'hFFFF);
    push_ticks(4);
    push_acc(16'h7FFF);
    push_ticks(1);
    push_acc(16'h8000);
    push_load(32'd10, 32'hFFFF_FFF6, 16'd7, 16'h7FFF);
    push_ticks(3);
    push_load(32'h1234_5678, 32'h1234_5678, 16'd3, 16'h0000);
    push_ticks(1);

    // Random ramps: load, a run of ticks, with overwrites, unused codes and reloads mixed in
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin
          start_v = $urandom;
          target_v = $urandom;
        end
        4: begin
          start_v = 32'h7FFF_FFFF - $urandom_range(0, 40000);
          target_v = 32'h7FFF_FFFF - $urandom_range(0, 3);
        end
        5: begin
          start_v = 32'h8000_0000 + $urandom_range(0, 40000);
          target_v = 32'h8000_0000 + $urandom_range(0, 3);
        end
        default: begin
          start_v = $urandom;
          target_v = $urandom_range(0, 1) ? start_v + $urandom_range(0, 200)
                                          : start_v - $urandom_range(0, 200);
        end
      endcase
      case ($urandom_range(0, 6))
        0: step_v = $urandom_range(0, 8);
        1: step_v = $urandom_range(0, 16'h7FFF);
        2: step_v = 16'h7FFF;
        3, 4: step_v = 16'h0000 - $urandom_range(1, 6);
        5: step_v = $urandom;
        default: step_v = 16'h8000;
      endcase
      case ($urandom_range(0, 7))
        0: phase_v = 16'h0000;
        1: phase_v = 16'h8000;
        2: phase_v = 16'hFFFF;
        3: phase_v = 16'h7FFF;
        default: phase_v = $urandom;
      endcase
      push_load(start_v, target_v, step_v, phase_v);
      n_random++;
      n_ticks = $urandom_range(1, 24);
      repeat (n_ticks) begin
        case ($urandom_range(0, 19))
          0: push_acc($urandom);
          1: pending_cmds.push_back(junk_cmd(FUNC_UNUSED));
          2: pending_cmds.push_back(junk_cmd(FUNC_LOAD));
          default: push_ticks(1);
        endcase
        n_random++;
      end
    end

    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
